// ===== rtl/assert_macros.svh =====
// Assertion macros used by the tokenizer core; they use the module's clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cif_tok_pkg.sv =====
// Types, character codes and helper functions for the CIF text tokenizer.
`timescale 1ns / 1ps
package cif_tok_pkg;

  localparam int CHAR_W  = 8;
  localparam int TOKEN_W = 32;
  localparam int CLASS_W = 3;

  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;

  localparam logic [CLASS_W-1:0] CLS_PLAIN  = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_TAG    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_LOOP   = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_STOP   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_PREFIX = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_BARE,
    MODE_QUOTED,
    MODE_QPEND,
    MODE_FIELD
  } mode_t;

  typedef enum logic [2:0] {
    KW_NONE,
    KW_LOOP,
    KW_STOP,
    KW_DATA,
    KW_SAVE,
    KW_S
  } kw_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_end;
  } tok_item_t;

  typedef struct packed {
    logic               has_token;
    logic [TOKEN_W-1:0] token_start;
    logic [TOKEN_W-1:0] token_len;
    logic               quoted;
    logic [CLASS_W-1:0] token_class;
    logic               is_null;
    logic               at_end;
  } tok_result_t;

  typedef struct packed {
    logic      valid;
    tok_item_t item;
  } tok_step_t;

  typedef struct packed {
    logic        valid;
    tok_result_t res;
  } tok_emit_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | 8'h20) : c;
  endfunction

  // Expected lower-case letter of a keyword at a given index (0..4).
  function automatic logic [CHAR_W-1:0] kw_char(input kw_t k, input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    c = 8'h00;
    case (k)
      KW_LOOP: begin
        case (idx)
          3'd0: c = "l";
          3'd1: c = "o";
          3'd2: c = "o";
          3'd3: c = "p";
          3'd4: c = "_";
          default: c = 8'h00;
        endcase
      end
      KW_STOP: begin
        case (idx)
          3'd0: c = "s";
          3'd1: c = "t";
          3'd2: c = "o";
          3'd3: c = "p";
          3'd4: c = "_";
          default: c = 8'h00;
        endcase
      end
      KW_DATA: begin
        case (idx)
          3'd0: c = "d";
          3'd1: c = "a";
          3'd2: c = "t";
          3'd3: c = "a";
          3'd4: c = "_";
          default: c = 8'h00;
        endcase
      end
      KW_SAVE: begin
        case (idx)
          3'd0: c = "s";
          3'd1: c = "a";
          3'd2: c = "v";
          3'd3: c = "e";
          3'd4: c = "_";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/cif_tok_in_if.sv =====
// Character input channel of the tokenizer.
`timescale 1ns / 1ps
interface cif_tok_in_if import cif_tok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              is_end;

  modport source (output valid, ch, is_end, input ready);
  modport sink (input valid, ch, is_end, output ready);
endinterface

// ===== rtl/cif_tok_out_if.sv =====
// Token result channel of the tokenizer.
`timescale 1ns / 1ps
interface cif_tok_out_if import cif_tok_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               has_token;
  logic [TOKEN_W-1:0] token_start;
  logic [TOKEN_W-1:0] token_len;
  logic               quoted;
  logic [CLASS_W-1:0] token_class;
  logic               is_null;
  logic               at_end;

  modport source (output valid, has_token, token_start, token_len, quoted, token_class,
                  is_null, at_end, input ready);
  modport sink (input valid, has_token, token_start, token_len, quoted, token_class,
                is_null, at_end, output ready);
endinterface

// ===== rtl/cif_text_tokenizer_top.sv =====
// Top level of the CIF text tokenizer.
// Usage:
//   in_if carries one text character per transaction (ch), or an end marker
//   (is_end = 1) that closes the text; out_if carries one token per transaction
//   with start offset, length, quoted flag, class and null mark.
//   Every end marker gives exactly one result with at_end set; has_token is 0
//   when no token was open. Offsets count from 0 and restart after each end.
// Timing:
//   A character is held in the input register, then scanned; the result (if
//   any) is registered in the result register and is shown on out_if from
//   there. Throughput is one character per cycle while no result waits with
//   out_if.ready low.
// Reset (rst_n low, synchronous): both channel registers empty, scanner
//   between tokens at offset 0 and at line start.
// Stall: while out_if.ready is low with a result waiting, the scanner holds;
//   the input register still accepts a character if it is empty, then in_if.ready drops.
`timescale 1ns / 1ps
module cif_text_tokenizer_top import cif_tok_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  cif_tok_in_if.sink    in_if,
  cif_tok_out_if.source out_if
);

  tok_step_t stp;
  tok_emit_t em;
  logic      free;

  cif_tok_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (free),
    .stp   (stp)
  );

  cif_tok_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .stp   (stp),
    .em    (em)
  );

  cif_tok_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .em     (em),
    .free   (free),
    .out_if (out_if)
  );

endmodule

// ===== rtl/cif_tok_in_reg.sv =====
// Input register: holds one accepted character until the scanner takes it.
`timescale 1ns / 1ps
module cif_tok_in_reg import cif_tok_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cif_tok_in_if.sink        in_if,
  input  logic              adv,
  output tok_step_t         stp
);

  logic      valid_r;
  logic      valid_nxt;
  tok_item_t item_r;
  logic      take;

  assign in_if.ready = !valid_r || adv;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.ch     <= in_if.ch;
      item_r.is_end <= in_if.is_end;
    end
  end

  assign stp = '{valid: valid_r && adv, item: item_r};

endmodule

// ===== rtl/cif_tok_core.sv =====
// Scanner state and per-character token logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cif_tok_core import cif_tok_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tok_step_t stp,
  output tok_emit_t em
);

  localparam int OB = OFFSET_BITS;

  mode_t             mode_r, mode_nxt;
  logic [OB-1:0]     pos_r, pos_nxt;
  logic [OB-1:0]     start_r, start_nxt;
  logic              qdbl_r, qdbl_nxt;
  logic              prev_nl_r, prev_nl_nxt;
  logic              fpn_r, fpn_nxt;
  logic [CHAR_W-1:0] fc_r, fc_nxt;
  kw_t               kw_r, kw_nxt;

  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] lc;
  logic [CHAR_W-1:0] quote;
  logic [CHAR_W-1:0] fc_upd;
  logic              ws;
  logic              in_token;
  logic [OB-1:0]     pos_inc;
  logic [OB-1:0]     len0;
  logic [OB-1:0]     len1;
  logic [OB:0]       start_p1;

  function automatic logic [CLASS_W-1:0] bare_class(input logic [OB-1:0] len,
                                                    input logic [CHAR_W-1:0] fc,
                                                    input kw_t kw);
    logic [CLASS_W-1:0] cls;
    cls = CLS_PLAIN;
    if (fc == CH_USCORE && len > OB'(1)) begin
      cls = CLS_TAG;
    end else if (kw == KW_LOOP && len == OB'(5)) begin
      cls = CLS_LOOP;
    end else if (kw == KW_STOP && len == OB'(5)) begin
      cls = CLS_STOP;
    end else if ((kw == KW_DATA || kw == KW_SAVE) && len >= OB'(5)) begin
      cls = CLS_PREFIX;
    end
    return cls;
  endfunction

  function automatic logic null_mark(input logic [OB-1:0] len, input logic [CHAR_W-1:0] fc);
    return (len == OB'(1)) && (fc == CH_DOT || fc == CH_QMARK);
  endfunction

  assign ch       = stp.item.ch;
  assign lc       = to_lower(ch);
  assign ws       = is_ws(ch);
  assign quote    = qdbl_r ? CH_DQUOTE : CH_SQUOTE;
  assign in_token = (mode_r == MODE_BARE) || (mode_r == MODE_QUOTED) ||
                    (mode_r == MODE_QPEND) || (mode_r == MODE_FIELD);
  assign fc_upd   = (in_token && pos_r == start_r) ? ch : fc_r;
  assign pos_inc  = (pos_r == {OB{1'b1}}) ? pos_r : pos_r + OB'(1);
  assign len0     = (pos_r > start_r) ? pos_r - start_r : '0;
  assign start_p1 = {1'b0, start_r} + (OB+1)'(1);
  assign len1     = ({1'b0, pos_r} > start_p1) ? OB'({1'b0, pos_r} - start_p1) : '0;

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    qdbl_nxt    = qdbl_r;
    prev_nl_nxt = prev_nl_r;
    fpn_nxt     = fpn_r;
    fc_nxt      = fc_r;
    kw_nxt      = kw_r;
    em          = '0;

    if (stp.valid && stp.item.is_end) begin
      // Flush any open token, then return to the reset state.
      em.valid      = 1'b1;
      em.res.at_end = 1'b1;
      case (mode_r)
        MODE_BARE: begin
          em.res.has_token   = 1'b1;
          em.res.token_start = TOKEN_W'(start_r);
          em.res.token_len   = TOKEN_W'(len0);
          em.res.token_class = bare_class(len0, fc_r, kw_r);
          em.res.is_null     = null_mark(len0, fc_r);
        end
        MODE_QUOTED, MODE_FIELD: begin
          em.res.has_token   = 1'b1;
          em.res.token_start = TOKEN_W'(start_r);
          em.res.token_len   = TOKEN_W'(len0);
          em.res.quoted      = 1'b1;
          em.res.is_null     = null_mark(len0, fc_r);
        end
        MODE_QPEND: begin
          em.res.has_token   = 1'b1;
          em.res.token_start = TOKEN_W'(start_r);
          em.res.token_len   = TOKEN_W'(len1);
          em.res.quoted      = 1'b1;
          em.res.is_null     = null_mark(len1, fc_r);
        end
        default: begin
        end
      endcase
      mode_nxt    = MODE_IDLE;
      pos_nxt     = '0;
      start_nxt   = '0;
      qdbl_nxt    = 1'b0;
      prev_nl_nxt = 1'b1;
      fpn_nxt     = 1'b0;
      fc_nxt      = '0;
      kw_nxt      = KW_NONE;
    end else if (stp.valid) begin
      fc_nxt = fc_upd;
      case (mode_r)
        MODE_IDLE: begin
          if (ws) begin
          end else if (ch == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (ch == CH_SEMI && prev_nl_r) begin
            mode_nxt  = MODE_FIELD;
            start_nxt = pos_inc;
            fpn_nxt   = 1'b0;
            fc_nxt    = '0;
          end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
            mode_nxt  = MODE_QUOTED;
            qdbl_nxt  = (ch == CH_DQUOTE);
            start_nxt = pos_inc;
            fc_nxt    = '0;
          end else begin
            mode_nxt  = MODE_BARE;
            start_nxt = pos_r;
            fc_nxt    = ch;
            if (lc == "l") begin
              kw_nxt = KW_LOOP;
            end else if (lc == "d") begin
              kw_nxt = KW_DATA;
            end else if (lc == "s") begin
              kw_nxt = KW_S;
            end else begin
              kw_nxt = KW_NONE;
            end
          end
        end
        MODE_COMMENT: begin
          if (ch == CH_LF) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_BARE: begin
          if (ws) begin
            em.valid           = 1'b1;
            em.res.has_token   = 1'b1;
            em.res.token_start = TOKEN_W'(start_r);
            em.res.token_len   = TOKEN_W'(len0);
            em.res.token_class = bare_class(len0, fc_upd, kw_r);
            em.res.is_null     = null_mark(len0, fc_upd);
            mode_nxt           = MODE_IDLE;
          end else if (kw_r == KW_S) begin
            // Split the shared 's' prefix into stop_ or save_.
            if (lc == "t") begin
              kw_nxt = KW_STOP;
            end else if (lc == "a") begin
              kw_nxt = KW_SAVE;
            end else begin
              kw_nxt = KW_NONE;
            end
          end else if (kw_r != KW_NONE) begin
            if (len0 < OB'(5)) begin
              if (lc != kw_char(kw_r, len0[2:0])) begin
                kw_nxt = KW_NONE;
              end
            end else if (kw_r == KW_LOOP || kw_r == KW_STOP) begin
              kw_nxt = KW_NONE;
            end
          end
        end
        MODE_QUOTED: begin
          if (ch == quote) begin
            mode_nxt = MODE_QPEND;
          end
        end
        MODE_QPEND: begin
          // A repeated quote stays pending; whitespace closes; anything else reopens.
          if (ch == quote) begin
          end else if (ws) begin
            em.valid           = 1'b1;
            em.res.has_token   = 1'b1;
            em.res.token_start = TOKEN_W'(start_r);
            em.res.token_len   = TOKEN_W'(len1);
            em.res.quoted      = 1'b1;
            em.res.is_null     = null_mark(len1, fc_upd);
            mode_nxt           = MODE_IDLE;
          end else begin
            mode_nxt = MODE_QUOTED;
          end
        end
        MODE_FIELD: begin
          if (ch == CH_SEMI && fpn_r) begin
            em.valid           = 1'b1;
            em.res.has_token   = 1'b1;
            em.res.token_start = TOKEN_W'(start_r);
            em.res.token_len   = TOKEN_W'(len1);
            em.res.quoted      = 1'b1;
            em.res.is_null     = null_mark(len1, fc_upd);
            mode_nxt           = MODE_IDLE;
            fpn_nxt            = 1'b0;
          end else begin
            fpn_nxt = (ch == CH_LF);
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
      prev_nl_nxt = (ch == CH_LF);
      pos_nxt     = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      pos_r     <= '0;
      start_r   <= '0;
      qdbl_r    <= 1'b0;
      prev_nl_r <= 1'b1;
      fpn_r     <= 1'b0;
      fc_r      <= '0;
      kw_r      <= KW_NONE;
    end else begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      qdbl_r    <= qdbl_nxt;
      prev_nl_r <= prev_nl_nxt;
      fpn_r     <= fpn_nxt;
      fc_r      <= fc_nxt;
      kw_r      <= kw_nxt;
    end
  end

  `ASSERT_IMP(a_bare_result_is_end, em.valid && !em.res.has_token, em.res.at_end, "tokenless result without end marker")
  `ASSERT_NXT(a_end_restarts, stp.valid && stp.item.is_end, mode_r == MODE_IDLE && pos_r == '0 && prev_nl_r, "scanner not restarted after end marker")
  `ASSERT_NXT(a_pos_monotonic, stp.valid && !stp.item.is_end, pos_r >= $past(pos_r), "position went backwards within text")

endmodule

// ===== rtl/cif_tok_out_reg.sv =====
// Result register: holds one token transaction until the receiver takes it.
`timescale 1ns / 1ps
module cif_tok_out_reg import cif_tok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tok_emit_t    em,
  output logic         free,
  cif_tok_out_if.source out_if
);

  logic        valid_r;
  logic        valid_nxt;
  tok_result_t res_r;

  assign free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (em.valid) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (em.valid) begin
      res_r <= em.res;
    end
  end

  assign out_if.valid       = valid_r;
  assign out_if.has_token   = res_r.has_token;
  assign out_if.token_start = res_r.token_start;
  assign out_if.token_len   = res_r.token_len;
  assign out_if.quoted      = res_r.quoted;
  assign out_if.token_class = res_r.token_class;
  assign out_if.is_null     = res_r.is_null;
  assign out_if.at_end      = res_r.at_end;

endmodule
